// ===== hdl/mm_pkg.sv =====
// Shared types, codes and default sizes of the matrix product engine.
package mm_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned MAX_DIM_DEF    = 16;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned ACC_BITS   = 36;
  localparam int unsigned IDX_BITS   = 4;
  localparam int unsigned IN_BITS    = 16;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;

  // Size register reset value.
  localparam logic [CFG_W-1:0] DIM_RESET = 5'd16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

  // Request actions.
  localparam logic [1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Request payload.
  typedef struct packed {
    logic [1:0]                 action;
    logic [IDX_BITS-1:0]        row;
    logic [IDX_BITS-1:0]        col;
    logic signed [IN_BITS-1:0]  value;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [IDX_BITS-1:0]        result_row;
    logic [IDX_BITS-1:0]        result_col;
    logic signed [ACC_BITS-1:0] dot;
    logic                       status;
  } rsp_t;

endpackage

// ===== hdl/mm_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct.
interface mm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mm_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module mm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/matrix_multiply.sv =====
// Matrix product engine: two entry stores and a multiply-accumulate sequencer.
//
//   channel   dir  handshake          payload
//   req_i     in   valid/ready        action, row, col, value
//   rsp_o     out  valid/ready        result_row, result_col, dot, status
//   cfg_*     in   cfg_we_i only      cfg_idx_i, cfg_data_i (rows_a, inner, cols_b)
//
// A load request's write lands in the store at the accept edge.
// A compute request issues one store read per term through the
// single read port of each store, then the product and accumulate stages drain.
// An out-of-range compute, or one with inner of zero, skips the term reads.
// Reset is asynchronous, active low; the stores need no clearing pass.
// Loads are taken while a result waits; a finished compute waits for the output slot.
module matrix_multiply #(
  parameter int unsigned MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int unsigned VALUE_BITS = mm_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mm_stream_if.sink                    req_i,
  mm_stream_if.source                  rsp_o,
  input  logic                         cfg_we_i,
  input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mm_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned CMPW  = (DW > mm_pkg::CFG_W) ? DW : mm_pkg::CFG_W;
  localparam int unsigned PW    = 2 * VALUE_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // Size registers.
  logic [mm_pkg::CFG_W-1:0] rows_a_q, inner_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= mm_pkg::DIM_RESET;
      inner_q  <= mm_pkg::DIM_RESET;
      cols_b_q <= mm_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mm_pkg::CFG_ROWS_A: rows_a_q <= cfg_data_i;
        mm_pkg::CFG_INNER:  inner_q  <= cfg_data_i;
        mm_pkg::CFG_COLS_B: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sizes above MAX_DIM act as MAX_DIM.
  function automatic logic [CMPW-1:0] clamp_dim(input logic [mm_pkg::CFG_W-1:0] v);
    logic [CMPW-1:0] w;
    w = CMPW'(v);
    return (w > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : w;
  endfunction

  logic [CMPW-1:0] ra, ni, cb;
  assign ra = clamp_dim(rows_a_q);
  assign ni = clamp_dim(inner_q);
  assign cb = clamp_dim(cols_b_q);

  // Sequencer registers.
  state_e                       state_q, state_d;
  logic [CMPW-1:0]              issue_q, issue_d;
  logic                         rd_vld_q, rd_vld_d;
  logic                         mul_vld_q, mul_vld_d;
  logic [mm_pkg::IDX_BITS-1:0]  row_q, row_d, col_q, col_d;
  logic                         status_q, status_d;
  logic signed [PW-1:0]         prod_q, prod_d;
  logic signed [mm_pkg::ACC_BITS-1:0] acc_q, acc_d;
  logic                         rsp_valid_q, rsp_valid_d;
  mm_pkg::rsp_t                 rsp_q, rsp_d;

  // Store ports.
  logic                  a_we, b_we, rd_en;
  logic [AW-1:0]         wr_addr, a_raddr, b_raddr;
  logic [VALUE_BITS-1:0] wr_data, a_rdata, b_rdata;

  logic [CMPW-1:0] req_row, req_col;
  logic            issuing;
  logic            out_free;

  assign req_row  = CMPW'(req_i.data.row);
  assign req_col  = CMPW'(req_i.data.col);
  assign issuing  = (issue_q < ni);
  assign out_free = !rsp_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == ST_IDLE);
  assign wr_addr = AW'(req_i.data.row) * AW'(MAX_DIM) + AW'(req_i.data.col);
  assign wr_data = VALUE_BITS'($unsigned(req_i.data.value));
  assign a_raddr = AW'(row_q) * AW'(MAX_DIM) + AW'(issue_q);
  assign b_raddr = AW'(issue_q) * AW'(MAX_DIM) + AW'(col_q);
  assign rd_en   = (state_q == ST_RUN) && issuing;

  // Request decode, term issue, multiply and accumulate.
  always_comb begin
    state_d     = state_q;
    issue_d     = issue_q;
    rd_vld_d    = rd_en;
    mul_vld_d   = rd_vld_q;
    row_d       = row_q;
    col_d       = col_q;
    status_d    = status_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    a_we        = 1'b0;
    b_we        = 1'b0;

    if (rd_vld_q) begin
      prod_d = $signed(a_rdata) * $signed(b_rdata);
    end
    if (mul_vld_q) begin
      acc_d = acc_q + mm_pkg::ACC_BITS'(prod_q);
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          case (req_i.data.action)
            mm_pkg::ACT_LOAD_A: begin
              a_we = (req_row < ra) && (req_col < ni);
            end
            mm_pkg::ACT_LOAD_B: begin
              b_we = (req_row < ni) && (req_col < cb);
            end
            mm_pkg::ACT_COMPUTE: begin
              row_d   = req_i.data.row;
              col_d   = req_i.data.col;
              acc_d   = '0;
              issue_d = '0;
              if ((req_row < ra) && (req_col < cb)) begin
                status_d = mm_pkg::STATUS_OK;
                state_d  = (ni == '0) ? ST_DONE : ST_RUN;
              end else begin
                status_d = mm_pkg::STATUS_RANGE;
                state_d  = ST_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (issuing) begin
          issue_d = issue_q + CMPW'(1);
        end else if (!rd_vld_q && !mul_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          rsp_valid_d      = 1'b1;
          rsp_d.result_row = row_q;
          rsp_d.result_col = col_q;
          rsp_d.dot        = acc_q;
          rsp_d.status     = status_q;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      mul_vld_q   <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      status_q    <= mm_pkg::STATUS_OK;
      prod_q      <= '0;
      acc_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      rd_vld_q    <= rd_vld_d;
      mul_vld_q   <= mul_vld_d;
      row_q       <= row_d;
      col_q       <= col_d;
      status_q    <= status_d;
      prod_q      <= prod_d;
      acc_q       <= acc_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Left and right entry stores.
  mm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_left_store (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_right_store (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

`ifndef ASSERT_OFF
  // Store writes never overlap a compute's reads.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((a_we || b_we) && rd_en))
    else $error("store write during compute read");

  // The term counter never passes the inner size.
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (issue_q <= ni))
    else $error("term counter past inner size");

  // The pipeline is empty once a compute reaches its result.
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (!rd_vld_q && !mul_vld_q))
    else $error("result taken before pipeline drained");

  // An out-of-range result carries a zero dot product.
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.status == mm_pkg::STATUS_RANGE)) |-> (rsp_q.dot == '0))
    else $error("out-of-range result with nonzero dot");
`endif

endmodule
